/* hdl/utf8_code_point_encoder_macros.svh */
// Assertion macros shared by the encoder RTL.
// Each macro expects clk and rst_n in scope.
`ifndef UTF8_CODE_POINT_ENCODER_MACROS_SVH
`define UTF8_CODE_POINT_ENCODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UTF8ENC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UTF8ENC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/utf8enc_pkg.sv */
package utf8enc_pkg;

  localparam int CP_W   = 32;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 3;

  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;

  // Length thresholds of the six-byte form
  localparam cp_t MAX_LEN1 = 32'h0000_007F;
  localparam cp_t MAX_LEN2 = 32'h0000_07FF;
  localparam cp_t MAX_LEN3 = 32'h0000_FFFF;
  localparam cp_t MAX_LEN4 = 32'h001F_FFFF;
  localparam cp_t MAX_LEN5 = 32'h03FF_FFFF;
  localparam cp_t MAX_LEN6 = 32'h7FFF_FFFF;

  localparam byte_t CONT_MARK    = 8'h80;
  localparam byte_t PAYLOAD_MASK = 8'h3F;

  // Sequence length in bytes; values above the six-byte range count as one
  function automatic len_t enc_len(input cp_t cp);
    len_t len;
    if (cp <= MAX_LEN1 || cp > MAX_LEN6) begin
      len = 3'd1;
    end else if (cp <= MAX_LEN2) begin
      len = 3'd2;
    end else if (cp <= MAX_LEN3) begin
      len = 3'd3;
    end else if (cp <= MAX_LEN4) begin
      len = 3'd4;
    end else if (cp <= MAX_LEN5) begin
      len = 3'd5;
    end else begin
      len = 3'd6;
    end
    return len;
  endfunction

  // Leading ones of the lead byte for a given length
  function automatic byte_t lead_mark(input len_t len);
    byte_t mark;
    case (len)
      3'd2:    mark = 8'hC0;
      3'd3:    mark = 8'hE0;
      3'd4:    mark = 8'hF0;
      3'd5:    mark = 8'hF8;
      3'd6:    mark = 8'hFC;
      default: mark = 8'h00;
    endcase
    return mark;
  endfunction

endpackage

/* hdl/utf8enc_if.sv */
interface utf8enc_cp_if;
  import utf8enc_pkg::*;

  logic valid;
  logic ready;
  cp_t  code_point;

  modport source (output valid, output code_point, input ready);
  modport sink   (input valid, input code_point, output ready);
endinterface

interface utf8enc_byte_if;
  import utf8enc_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  last_byte;
  logic  too_large;

  modport source (output valid, output out_byte, output last_byte, output too_large,
                  input ready);
  modport sink   (input valid, input out_byte, input last_byte, input too_large,
                  output ready);
endinterface

/* hdl/utf8_code_point_encoder.sv */
// UTF-8 encoder, original form with sequences of up to six bytes.
// in_cp carries one 32-bit code point per item (valid/ready, accepted when
// both are high). out_chan carries one byte per item, lead byte first, with
// last_byte on the final byte of each sequence. A code point above
// 0x7FFFFFFF yields a single item with too_large set and a zero byte.
// A byte reaches out_chan through the input stage register, then the
// output register, after its code point is accepted.
// Throughput: one output byte per cycle while the receiver holds ready
// high; a code point yields 1 to 6 bytes, which the output register moves
// on one by one. The next code point is taken in the cycle its predecessor's
// last byte moves into the output register, so items follow back to back.
// Reset empties both the input stage and the output register; no item is
// pending afterward. When the receiver holds ready low, the output register
// keeps its byte, the input stage keeps its code point and in_cp.ready
// drops once the stage holds an item that cannot advance.
`include "utf8_code_point_encoder_macros.svh"

module utf8_code_point_encoder (
  input  logic                  clk,
  input  logic                  rst_n,
  utf8enc_cp_if.sink            in_cp,
  utf8enc_byte_if.source        out_chan
);
  import utf8enc_pkg::*;

  // Input stage: code point being split into bytes
  logic  busy_r,  busy_nxt;
  cp_t   cp_r,    cp_nxt;
  len_t  len_r,   len_nxt;
  len_t  rem_r,   rem_nxt;
  logic  first_r, first_nxt;
  logic  err_r,   err_nxt;

  // Output register
  logic  out_vld_r,  out_vld_nxt;
  byte_t out_byte_r, out_byte_nxt;
  logic  out_last_r, out_last_nxt;
  logic  out_err_r,  out_err_nxt;

  logic  load;
  logic  stage_last;
  logic  accept;
  cp_t   group;
  byte_t byte_val;
  len_t  new_len;

  assign load       = busy_r && (!out_vld_r || out_chan.ready);
  assign stage_last = (rem_r == '0);
  assign in_cp.ready = !busy_r || (load && stage_last);
  assign accept     = in_cp.valid && in_cp.ready;
  assign new_len    = enc_len(in_cp.code_point);

  // Select the six-bit group that this byte carries
  always_comb begin
    case (rem_r)
      3'd0:    group = cp_r;
      3'd1:    group = cp_r >> 6;
      3'd2:    group = cp_r >> 12;
      3'd3:    group = cp_r >> 18;
      3'd4:    group = cp_r >> 24;
      3'd5:    group = cp_r >> 30;
      default: group = '0;
    endcase
  end

  // Form the byte: error, lead byte or continuation byte
  always_comb begin
    if (err_r) begin
      byte_val = '0;
    end else if (first_r) begin
      byte_val = lead_mark(len_r) | group[BYTE_W-1:0];
    end else begin
      byte_val = CONT_MARK | (group[BYTE_W-1:0] & PAYLOAD_MASK);
    end
  end

  // Advance the input stage, take a new item when the stage frees up
  always_comb begin
    busy_nxt  = busy_r;
    cp_nxt    = cp_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    first_nxt = first_r;
    err_nxt   = err_r;
    if (load) begin
      rem_nxt   = rem_r - 3'd1;
      first_nxt = 1'b0;
      if (stage_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (accept) begin
      busy_nxt  = 1'b1;
      cp_nxt    = in_cp.code_point;
      len_nxt   = new_len;
      rem_nxt   = new_len - 3'd1;
      first_nxt = 1'b1;
      err_nxt   = in_cp.code_point > MAX_LEN6;
    end
  end

  // Load or drain the output register
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    out_err_nxt  = out_err_r;
    if (load) begin
      out_vld_nxt  = 1'b1;
      out_byte_nxt = byte_val;
      out_last_nxt = stage_last;
      out_err_nxt  = err_r;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
    end
    cp_r       <= cp_nxt;
    len_r      <= len_nxt;
    rem_r      <= rem_nxt;
    first_r    <= first_nxt;
    err_r      <= err_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_chan.valid     = out_vld_r;
  assign out_chan.out_byte  = out_byte_r;
  assign out_chan.last_byte = out_last_r;
  assign out_chan.too_large = out_err_r;

  // Byte countdown stays inside the sequence length
  `UTF8ENC_ASSERT_SAME(a_rem_in_range, busy_r, rem_r < len_r, "byte index beyond length")
  // An oversized code point is a one-byte item
  `UTF8ENC_ASSERT_SAME(a_err_len, busy_r && err_r, len_r == 3'd1, "error item longer than one")
  // Error result carries a zero byte and ends the sequence
  `UTF8ENC_ASSERT_SAME(a_err_out, out_vld_r && out_err_r,
                       out_last_r && out_byte_r == '0, "malformed error result")
  // A non-final byte leaves the stage busy with one byte fewer to go
  `UTF8ENC_ASSERT_NEXT(a_countdown, load && !stage_last,
                       busy_r && rem_r == $past(rem_r) - 3'd1, "byte countdown slipped")

endmodule

/* tb/tb_utf8_code_point_encoder.sv */
module tb_utf8_code_point_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8enc_pkg::*;

  localparam int RANDOM_ITEMS = 456;
  localparam int CALM_ITEMS   = 80;
  localparam int DRAIN_AT     = 300;
  localparam int HOLD_AT      = 150;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int MAX_REPORTS  = 40;

  // One stimulus row; typed rows carry their byte sequence, lead byte in the top byte used
  typedef struct packed {
    cp_t         cp;
    logic        typed;
    logic [2:0]  n;
    logic [47:0] seq;
    logic        err;
  } stim_row_t;

  // One result item as the block should emit it
  typedef struct packed {
    byte_t value;
    logic  last;
    logic  too_large;
  } utf8_byte_t;

  localparam stim_row_t DIRECTED [25] = '{
    '{32'h0000_0000, 1'b1, 3'd1, 48'h00,           1'b0},
    '{32'h0000_007F, 1'b1, 3'd1, 48'h7F,           1'b0},
    '{32'h0000_0080, 1'b1, 3'd2, 48'hC280,         1'b0},
    '{32'h0000_07FF, 1'b1, 3'd2, 48'hDFBF,         1'b0},
    '{32'h0000_0800, 1'b1, 3'd3, 48'hE0A080,       1'b0},
    '{32'h0000_FFFF, 1'b1, 3'd3, 48'hEFBFBF,       1'b0},
    '{32'h0001_0000, 1'b1, 3'd4, 48'hF0908080,     1'b0},
    '{32'h001F_FFFF, 1'b1, 3'd4, 48'hF7BFBFBF,     1'b0},
    '{32'h0020_0000, 1'b1, 3'd5, 48'hF888808080,   1'b0},
    '{32'h03FF_FFFF, 1'b1, 3'd5, 48'hFBBFBFBFBF,   1'b0},
    '{32'h0400_0000, 1'b1, 3'd6, 48'hFC8480808080, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 3'd6, 48'hFDBFBFBFBFBF, 1'b0},
    '{32'h8000_0000, 1'b1, 3'd1, 48'h00,           1'b1},
    '{32'hFFFF_FFFF, 1'b1, 3'd1, 48'h00,           1'b1},
    // surrogates and values past the modern range are encoded normally
    '{32'h0000_D800, 1'b0, 3'd0, 48'h0,            1'b0},
    '{32'h0000_DFFF, 1'b0, 3'd0, 48'h0,            1'b0},
    '{32'h0010_FFFF, 1'b0, 3'd0, 48'h0,            1'b0},
    '{32'h0011_0000, 1'b0, 3'd0, 48'h0,            1'b0},
    '{32'h0000_0041, 1'b0, 3'd0, 48'h0,            1'b0},
    '{32'h0000_00E9, 1'b0, 3'd0, 48'h0,            1'b0},
    '{32'h0000_20AC, 1'b0, 3'd0, 48'h0,            1'b0},
    '{32'h0001_F600, 1'b0, 3'd0, 48'h0,            1'b0},
    '{32'h5555_5555, 1'b0, 3'd0, 48'h0,            1'b0},
    '{32'h2AAA_AAAA, 1'b0, 3'd0, 48'h0,            1'b0},
    '{32'hAAAA_AAAA, 1'b0, 3'd0, 48'h0,            1'b0}
  };

  logic clk;
  logic rst_n;

  utf8enc_cp_if   cp_ch();
  utf8enc_byte_if byte_ch();

  utf8_code_point_encoder i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cp   (cp_ch),
    .out_chan(byte_ch)
  );

  stim_row_t  offered_cps[$];
  utf8_byte_t utf8_bytes_due[$];
  int         fail_count;
  int         accepted_cps;
  int         stall_cycles;
  logic       calm;

  initial begin
    fail_count   = 0;
    accepted_cps = 0;
    stall_cycles = 0;
  end

  always begin
    clk = 1'b1;
    #5ns;
    clk = 1'b0;
    #5ns;
  end

  // Append the bytes that a code point encodes to
  function automatic void predict_utf8_bytes(input cp_t cp);
    int unsigned n;
    byte_t       ones;
    byte_t       lead;
    byte_t       group;
    ones = 8'hFF;
    if (cp > MAX_LEN6) begin
      utf8_bytes_due.push_back('{8'h00, 1'b1, 1'b1});
    end else if (cp <= MAX_LEN1) begin
      utf8_bytes_due.push_back('{cp[7:0], 1'b1, 1'b0});
    end else begin
      if (cp <= MAX_LEN2) n = 2;
      else if (cp <= MAX_LEN3) n = 3;
      else if (cp <= MAX_LEN4) n = 4;
      else if (cp <= MAX_LEN5) n = 5;
      else n = 6;
      lead = byte_t'(ones << (8 - n)) | byte_t'(cp >> (6 * (n - 1)));
      utf8_bytes_due.push_back('{lead, 1'b0, 1'b0});
      for (int k = 1; k < n; k++) begin
        group = byte_t'(cp >> (6 * (n - 1 - k))) & PAYLOAD_MASK;
        utf8_bytes_due.push_back('{CONT_MARK | group, k == n - 1, 1'b0});
      end
    end
  endfunction

  // Draw a code point from one of the six length ranges, the oversized range or the full 32-bit range, chosen evenly
  function automatic cp_t random_code_point();
    cp_t cp;
    case ($urandom_range(0, 7))
      0:       cp = $urandom_range(0, MAX_LEN1);
      1:       cp = $urandom_range(MAX_LEN1 + 1, MAX_LEN2);
      2:       cp = $urandom_range(MAX_LEN2 + 1, MAX_LEN3);
      3:       cp = $urandom_range(MAX_LEN3 + 1, MAX_LEN4);
      4:       cp = $urandom_range(MAX_LEN4 + 1, MAX_LEN5);
      5:       cp = $urandom_range(MAX_LEN5 + 1, MAX_LEN6);
      6:       cp = $urandom_range(MAX_LEN6 + 1, 32'hFFFF_FFFF);
      default: cp = $urandom();
    endcase
    return cp;
  endfunction

  // Offer one item and hold it until accepted
  task automatic offer_cp(input stim_row_t row);
    offered_cps.push_back(row);
    cp_ch.valid      <= 1'b1;
    cp_ch.code_point <= row.cp;
    do @(posedge clk); while (!cp_ch.ready);
  endtask

  // Drop valid for a random burst, except in the closing stretch
  task automatic idle_sender();
    if (!calm && $urandom_range(0, 5) == 0) begin
      cp_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Sender: reset, directed table, random items, then drain and report
  initial begin
    stim_row_t row;
    cp_ch.valid      <= 1'b0;
    cp_ch.code_point <= '0;
    rst_n            <= 1'b0;
    calm             <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      idle_sender();
      offer_cp(DIRECTED[i]);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
      if (i == DRAIN_AT) begin
        // pause until every byte so far has come out
        cp_ch.valid <= 1'b0;
        do @(negedge clk); while (utf8_bytes_due.size() != 0 || offered_cps.size() != 0);
        @(posedge clk);
      end else begin
        idle_sender();
      end
      row = '{random_code_point(), 1'b0, 3'd0, 48'h0, 1'b0};
      offer_cp(row);
    end

    cp_ch.valid <= 1'b0;
    do @(negedge clk); while (utf8_bytes_due.size() != 0 || offered_cps.size() != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, none in the closing stretch
  initial begin
    bit long_done;
    long_done = 1'b0;
    byte_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!long_done && accepted_cps >= HOLD_AT) begin
        byte_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_done = 1'b1;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        byte_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        byte_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Predict on each accepted code point, then check each accepted byte
  always @(posedge clk) begin : check_bytes
    stim_row_t  row;
    utf8_byte_t want;
    utf8_byte_t got;
    if (rst_n) begin
      if (cp_ch.valid && cp_ch.ready) begin
        row = offered_cps.pop_front();
        if (row.typed) begin
          for (int k = 0; k < row.n; k++) begin
            utf8_bytes_due.push_back('{row.seq[8 * (row.n - 1 - k) +: 8], k == row.n - 1,
                                       row.err});
          end
        end else begin
          predict_utf8_bytes(row.cp);
        end
        accepted_cps <= accepted_cps + 1;
      end
      if (byte_ch.valid && byte_ch.ready) begin
        got = '{byte_ch.out_byte, byte_ch.last_byte, byte_ch.too_large};
        if (utf8_bytes_due.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < MAX_REPORTS)
            $display("%0t: unexpected byte, expected none, got %02h last %0b too_large %0b",
                     $realtime, got.value, got.last, got.too_large);
        end else begin
          want = utf8_bytes_due.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < MAX_REPORTS)
              $display("%0t: mismatch, expected %02h/%0b/%0b, got %02h/%0b/%0b",
                       $realtime, want.value, want.last, want.too_large,
                       got.value, got.last, got.too_large);
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cp_ch.valid && cp_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule

/* files.f */
+incdir+hdl
hdl/utf8enc_pkg.sv
hdl/utf8enc_if.sv
hdl/utf8_code_point_encoder.sv
tb/tb_utf8_code_point_encoder.sv
